@@ rtl/bde_pkg.sv @@
// Package: command and status codes and item types for the deque engine.
`default_nettype none
package bde_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;
  localparam logic [2:0] CMD_WALK_FWD   = 3'd6;
  localparam logic [2:0] CMD_WALK_BACK  = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOW_EMPTY = 2'd1;
  localparam logic [1:0] ST_WAS_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

endpackage
`default_nettype wire

@@ rtl/bounded_deque_engine_top.sv @@
// Top level: ring-buffer deque with a slot step unit under a small sequencer.
// Push, or any command on an empty queue: busy in DECODE only, which sets the strobe.
// Pop and peek: busy in DECODE, which reads memory, and in OUT, which sets the strobe.
// Walk of N entries: OUT gives one result per cycle from the single memory read port.
// Results cannot be held off; the next item may be accepted while the last result shows.
// Synchronous reset empties the queue (pointers and count to zero); entry contents persist.
`default_nettype none
module bounded_deque_engine_top #(
  parameter int DEPTH = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  bde_pkg::in_item_t   item,
  output logic                busy,
  output logic                strobe,
  output bde_pkg::out_item_t  result
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_OUT    = 2'd2;

  logic [1:0]         state, state_next;
  logic [2:0]         cmd;
  logic signed [31:0] val;
  logic [IW-1:0]      front, front_next;
  logic [IW-1:0]      back, back_next;
  logic [CW-1:0]      count, count_next;
  logic [IW-1:0]      ptr, ptr_next;
  logic [CW-1:0]      remain, remain_next;
  logic [1:0]         pend, pend_next;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [IW-1:0]      addr;
  logic               we, re;

  logic               strobe_next;
  bde_pkg::out_item_t result_next;

  // shared slot step unit
  logic [IW-1:0] step_in, step_out;
  logic          step_down;

  always_comb begin
    if (step_down) begin
      step_out = (step_in == '0) ? IW'(DEPTH - 1) : step_in - 1'b1;
    end else begin
      step_out = (step_in == IW'(DEPTH - 1)) ? '0 : step_in + 1'b1;
    end
  end

  logic is_full, is_empty, is_walk;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign is_walk  = (cmd == bde_pkg::CMD_WALK_FWD) || (cmd == bde_pkg::CMD_WALK_BACK);

  always_comb begin
    state_next  = state;
    front_next  = front;
    back_next   = back;
    count_next  = count;
    ptr_next    = ptr;
    remain_next = remain;
    pend_next   = pend;
    strobe_next = 1'b0;
    result_next = result;
    we          = 1'b0;
    re          = 1'b0;
    addr        = ptr;
    step_in     = ptr;
    step_down   = (cmd == bde_pkg::CMD_WALK_BACK);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (cmd)
          bde_pkg::CMD_PUSH_FRONT: begin
            step_in = front; step_down = 1'b1; addr = step_out;
          end
          bde_pkg::CMD_PUSH_BACK: begin
            step_in = back; step_down = 1'b0; addr = back;
          end
          bde_pkg::CMD_POP_FRONT: begin
            step_in = front; step_down = 1'b0; addr = front;
          end
          bde_pkg::CMD_PEEK_FRONT, bde_pkg::CMD_WALK_FWD: begin
            step_in = front; step_down = 1'b0; addr = front;
          end
          default: begin
            step_in = back; step_down = 1'b1; addr = step_out;
          end
        endcase
        ptr_next    = addr;
        remain_next = count;
        if ((cmd == bde_pkg::CMD_PUSH_FRONT) || (cmd == bde_pkg::CMD_PUSH_BACK)) begin
          strobe_next = 1'b1;
          state_next  = S_IDLE;
          result_next = '{data: '0, status: bde_pkg::ST_OK, last: 1'b1};
          if (is_full) begin
            result_next.status = bde_pkg::ST_FULL;
          end else begin
            we         = 1'b1;
            count_next = count + 1'b1;
            if (cmd == bde_pkg::CMD_PUSH_FRONT) begin
              front_next = step_out;
            end else begin
              back_next = step_out;
            end
          end
        end else if (is_empty) begin
          strobe_next = 1'b1;
          state_next  = S_IDLE;
          result_next = '{data: '0, status: bde_pkg::ST_WAS_EMPTY, last: 1'b1};
        end else begin
          re         = 1'b1;
          state_next = S_OUT;
          pend_next  = bde_pkg::ST_OK;
          if (cmd == bde_pkg::CMD_POP_FRONT) begin
            front_next = step_out;
          end else if (cmd == bde_pkg::CMD_POP_BACK) begin
            back_next = step_out;
          end
          if ((cmd == bde_pkg::CMD_POP_FRONT) || (cmd == bde_pkg::CMD_POP_BACK)) begin
            count_next = count - 1'b1;
            if (count == CW'(1)) begin
              pend_next = bde_pkg::ST_NOW_EMPTY;
            end
          end
        end
      end
      S_OUT: begin
        strobe_next        = 1'b1;
        result_next.data   = rd_data;
        result_next.status = pend;
        result_next.last   = 1'b1;
        addr               = step_out;
        if (is_walk && (remain != CW'(1))) begin
          result_next.last = 1'b0;
          re               = 1'b1;
          ptr_next         = step_out;
          remain_next      = remain - 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= val;
    end
    if (re) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      front  <= '0;
      back   <= '0;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      front  <= front_next;
      back   <= back_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      cmd <= item.command;
      val <= item.push_value;
    end
    ptr    <= ptr_next;
    remain <= remain_next;
    pend   <= pend_next;
    result <= result_next;
  end

  assign busy = (state != S_IDLE);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("entry count above depth");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy) else $error("busy after final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy) else $error("walk ended without last");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.status == bde_pkg::ST_FULL) |-> is_full)
    else $error("full status with room left");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    strobe && ((result.status == bde_pkg::ST_FULL) ||
               (result.status == bde_pkg::ST_WAS_EMPTY)) |-> (result.data == '0))
    else $error("data nonzero on error status");

endmodule
`default_nettype wire
